/* src/hsk_pkg.sv */
package hsk_pkg;

  localparam logic [15:0] HANGUL_BASE = 16'hAC00;
  localparam logic [15:0] HANGUL_LAST = 16'hD7A3;
  localparam logic [15:0] ASCII_LOW   = 16'h0021;
  localparam logic [15:0] ASCII_HIGH  = 16'h007E;

  localparam int PER_INITIAL = 588;
  localparam int PER_MEDIAL  = 28;
  localparam int NUM_INITIAL = 19;
  localparam int NUM_MEDIAL  = 21;
  localparam int NUM_FINAL   = 28;
  localparam int KEYS_MAX    = 5;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int OFF_W = 14;
  localparam int INI_W = 5;
  localparam int REM_W = 10;
  localparam int MED_W = 5;
  localparam int FIN_W = 5;
  localparam int KEY_W = 7;
  localparam int CNT_W = 3;

  localparam logic [KEY_W-1:0] KEY_NONE = '0;

  typedef enum logic [1:0] {
    CLS_NONE,
    CLS_ASCII,
    CLS_HANGUL
  } hsk_class_e;

  typedef struct packed {
    logic [KEYS_MAX-1:0][KEY_W-1:0] keys;
    logic [CNT_W-1:0]               count;
    logic                           korean;
  } hsk_entry_t;

  function automatic logic [KEY_W-1:0] initial_key(input logic [INI_W-1:0] idx);
    logic [KEY_W-1:0] k;
    case (idx)
      5'd0:    k = 7'("r");
      5'd1:    k = 7'("R");
      5'd2:    k = 7'("s");
      5'd3:    k = 7'("e");
      5'd4:    k = 7'("E");
      5'd5:    k = 7'("f");
      5'd6:    k = 7'("a");
      5'd7:    k = 7'("q");
      5'd8:    k = 7'("Q");
      5'd9:    k = 7'("t");
      5'd10:   k = 7'("T");
      5'd11:   k = 7'("d");
      5'd12:   k = 7'("w");
      5'd13:   k = 7'("W");
      5'd14:   k = 7'("c");
      5'd15:   k = 7'("z");
      5'd16:   k = 7'("x");
      5'd17:   k = 7'("v");
      default: k = 7'("g");
    endcase
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] medial_key0(input logic [MED_W-1:0] idx);
    logic [KEY_W-1:0] k;
    case (idx)
      5'd0:    k = 7'("k");
      5'd1:    k = 7'("o");
      5'd2:    k = 7'("i");
      5'd3:    k = 7'("O");
      5'd4:    k = 7'("j");
      5'd5:    k = 7'("p");
      5'd6:    k = 7'("u");
      5'd7:    k = 7'("P");
      5'd8:    k = 7'("h");
      5'd9:    k = 7'("h");
      5'd10:   k = 7'("h");
      5'd11:   k = 7'("h");
      5'd12:   k = 7'("y");
      5'd13:   k = 7'("n");
      5'd14:   k = 7'("n");
      5'd15:   k = 7'("n");
      5'd16:   k = 7'("n");
      5'd17:   k = 7'("b");
      5'd18:   k = 7'("m");
      5'd19:   k = 7'("m");
      default: k = 7'("l");
    endcase
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] medial_key1(input logic [MED_W-1:0] idx);
    logic [KEY_W-1:0] k;
    case (idx)
      5'd9:    k = 7'("k");
      5'd10:   k = 7'("o");
      5'd11:   k = 7'("l");
      5'd14:   k = 7'("j");
      5'd15:   k = 7'("p");
      5'd16:   k = 7'("l");
      5'd19:   k = 7'("l");
      default: k = KEY_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] final_key0(input logic [FIN_W-1:0] idx);
    logic [KEY_W-1:0] k;
    case (idx)
      5'd1:    k = 7'("r");
      5'd2:    k = 7'("R");
      5'd3:    k = 7'("r");
      5'd4:    k = 7'("s");
      5'd5:    k = 7'("s");
      5'd6:    k = 7'("s");
      5'd7:    k = 7'("e");
      5'd8:    k = 7'("f");
      5'd9:    k = 7'("f");
      5'd10:   k = 7'("f");
      5'd11:   k = 7'("f");
      5'd12:   k = 7'("f");
      5'd13:   k = 7'("f");
      5'd14:   k = 7'("f");
      5'd15:   k = 7'("f");
      5'd16:   k = 7'("a");
      5'd17:   k = 7'("q");
      5'd18:   k = 7'("q");
      5'd19:   k = 7'("t");
      5'd20:   k = 7'("T");
      5'd21:   k = 7'("d");
      5'd22:   k = 7'("w");
      5'd23:   k = 7'("c");
      5'd24:   k = 7'("z");
      5'd25:   k = 7'("x");
      5'd26:   k = 7'("v");
      5'd27:   k = 7'("g");
      default: k = KEY_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] final_key1(input logic [FIN_W-1:0] idx);
    logic [KEY_W-1:0] k;
    case (idx)
      5'd3:    k = 7'("t");
      5'd5:    k = 7'("w");
      5'd6:    k = 7'("g");
      5'd9:    k = 7'("r");
      5'd10:   k = 7'("a");
      5'd11:   k = 7'("q");
      5'd12:   k = 7'("t");
      5'd13:   k = 7'("x");
      5'd14:   k = 7'("v");
      5'd15:   k = 7'("g");
      5'd18:   k = 7'("t");
      default: k = KEY_NONE;
    endcase
    return k;
  endfunction

endpackage

/* src/hsk_front.sv */
module hsk_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [15:0]       code_point_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output hsk_pkg::hsk_entry_t q_entry_o
);
  import hsk_pkg::*;

  logic             s0_v_q, s0_v_d;
  logic [15:0]      s0_cp_q;
  logic             s1_v_q, s1_v_d;
  hsk_class_e       s1_cls_q, s1_cls_d;
  logic [KEY_W-1:0] s1_chr_q;
  logic [INI_W-1:0] s1_ini_q, s1_ini_d;
  logic [REM_W-1:0] s1_rem_q, s1_rem_d;
  logic [OFF_W-1:0] off;
  logic             accept, s0_adv, s1_done;
  logic [MED_W-1:0] med;
  logic [FIN_W-1:0] fin;
  logic [KEY_W-1:0] m2, f0, f1;
  logic [CNT_W-1:0] n;
  hsk_entry_t       ent;

  assign s1_done    = s1_v_q && ((s1_cls_q == CLS_NONE) || !q_full_i);
  assign s0_adv     = s0_v_q && (!s1_v_q || s1_done);
  assign in_stall_o = s0_v_q && !s0_adv;
  assign accept     = in_valid_i && !in_stall_o;
  assign s0_v_d     = accept || (s0_v_q && !s0_adv);
  assign s1_v_d     = s0_adv || (s1_v_q && !s1_done);

  // classify and split off the initial
  always_comb begin
    off = OFF_W'(s0_cp_q - HANGUL_BASE);
    if (s0_cp_q >= ASCII_LOW && s0_cp_q <= ASCII_HIGH) begin
      s1_cls_d = CLS_ASCII;
    end else if (s0_cp_q >= HANGUL_BASE && s0_cp_q <= HANGUL_LAST) begin
      s1_cls_d = CLS_HANGUL;
    end else begin
      s1_cls_d = CLS_NONE;
    end
    s1_ini_d = '0;
    for (int k = 1; k < NUM_INITIAL; k++) begin
      if (off >= OFF_W'(k * PER_INITIAL)) begin
        s1_ini_d = INI_W'(k);
      end
    end
    s1_rem_d = REM_W'(off - OFF_W'(s1_ini_d) * OFF_W'(PER_INITIAL));
  end

  // split medial and final, build the key list
  always_comb begin
    med = '0;
    for (int k = 1; k < NUM_MEDIAL; k++) begin
      if (s1_rem_q >= REM_W'(k * PER_MEDIAL)) begin
        med = MED_W'(k);
      end
    end
    fin = FIN_W'(s1_rem_q - REM_W'(med) * REM_W'(PER_MEDIAL));
    m2  = medial_key1(med);
    f0  = final_key0(fin);
    f1  = final_key1(fin);
    ent = '0;
    n   = CNT_W'(2);
    ent.keys[0] = initial_key(s1_ini_q);
    ent.keys[1] = medial_key0(med);
    if (m2 != KEY_NONE) begin
      ent.keys[n] = m2;
      n = n + CNT_W'(1);
    end
    if (f0 != KEY_NONE) begin
      ent.keys[n] = f0;
      n = n + CNT_W'(1);
    end
    if (f1 != KEY_NONE) begin
      ent.keys[n] = f1;
      n = n + CNT_W'(1);
    end
    ent.count  = n;
    ent.korean = 1'b1;
    if (s1_cls_q == CLS_ASCII) begin
      ent        = '0;
      ent.keys[0] = s1_chr_q;
      ent.count  = CNT_W'(1);
      ent.korean = 1'b0;
    end
  end

  assign q_push_o  = s1_done && (s1_cls_q != CLS_NONE);
  assign q_entry_o = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      s1_v_q <= 1'b0;
    end else begin
      s0_v_q <= s0_v_d;
      s1_v_q <= s1_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s0_cp_q <= code_point_i;
    end
    if (s0_adv) begin
      s1_cls_q <= s1_cls_d;
      s1_chr_q <= s0_cp_q[KEY_W-1:0];
      s1_ini_q <= s1_ini_d;
      s1_rem_q <= s1_rem_d;
    end
  end

endmodule

/* src/hsk_queue.sv */
module hsk_queue #(
  parameter int Depth = hsk_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  hsk_pkg::hsk_entry_t entry_i,
  output logic                full_o,
  output logic                empty_o,
  input  logic                pop_i,
  output hsk_pkg::hsk_entry_t head_o
);
  import hsk_pkg::*;

  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int FillW = $clog2(Depth + 1);

  hsk_entry_t       mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0] fill_q, fill_d;

  assign full_o  = (fill_q == FillW'(Depth));
  assign empty_o = (fill_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + FillW'(1);
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - FillW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

/* src/hsk_back.sv */
module hsk_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  hsk_pkg::hsk_entry_t q_head_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [6:0]          key_code_o,
  output logic                is_korean_o,
  output logic [2:0]          run_length_o,
  output logic                last_of_run_o
);
  import hsk_pkg::*;

  logic             out_v_q, out_v_d;
  logic [KEY_W-1:0] key_q;
  logic             kor_q;
  logic [CNT_W-1:0] len_q;
  logic             last_q;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             load, last;

  assign load    = !q_empty_i && (!out_v_q || !out_stall_i);
  assign last    = (idx_q == q_head_i.count - CNT_W'(1));
  assign q_pop_o = load && last;
  assign out_v_d = load || (out_v_q && out_stall_i);

  always_comb begin
    idx_d = idx_q;
    if (load) begin
      idx_d = last ? '0 : idx_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      out_v_q <= out_v_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      key_q  <= q_head_i.keys[idx_q];
      kor_q  <= q_head_i.korean;
      len_q  <= q_head_i.count;
      last_q <= last;
    end
  end

  assign out_valid_o   = out_v_q;
  assign key_code_o    = key_q;
  assign is_korean_o   = kor_q;
  assign run_length_o  = len_q;
  assign last_of_run_o = last_q;

  a_ascii_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !kor_q |-> len_q == CNT_W'(1) && last_q)
    else $error("ascii word not a single-key run");

  a_korean_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && kor_q |-> len_q >= CNT_W'(2) && len_q <= CNT_W'(KEYS_MAX))
    else $error("hangul run length out of range");

  a_idx_in_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_empty_i |-> idx_q < q_head_i.count)
    else $error("key index beyond run");

endmodule

/* src/hangul_syllable_to_keystrokes.sv */
// channel | valid       | stall       | payload
// in      | in_valid_i  | in_stall_o  | code_point_i
// out     | out_valid_o | out_stall_i | key_code_o is_korean_o run_length_o last_of_run_o
//
// one code point accepted per cycle unless in_stall_o is high; one keystroke word leaves per cycle
// unless out_stall_i holds it, so a kept code point yields run_length words (1 to 5)
// from accept to first keystroke a code point passes two classify stages,
// the queue and the output register
// reset clears only the valid bits, queue pointers and fill count, and key index
// an output stall backs up through the queue, then stalls the input
module hangul_syllable_to_keystrokes #(
  parameter int QueueDepth = hsk_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] code_point_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  key_code_o,
  output logic        is_korean_o,
  output logic [2:0]  run_length_o,
  output logic        last_of_run_o
);
  import hsk_pkg::*;

  logic       push, pop, full, empty;
  hsk_entry_t entry, head;

  hsk_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .code_point_i (code_point_i),
    .q_full_i     (full),
    .q_push_o     (push),
    .q_entry_o    (entry)
  );

  hsk_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .empty_o (empty),
    .pop_i   (pop),
    .head_o  (head)
  );

  hsk_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (empty),
    .q_head_i      (head),
    .q_pop_o       (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .key_code_o    (key_code_o),
    .is_korean_o   (is_korean_o),
    .run_length_o  (run_length_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
